// ===== rtl/nvp_pkg.sv =====
// ----------------------------------------------------------------------------
// nvp_pkg
// shared types, constants and codes of the nearest vertex pick block
// ----------------------------------------------------------------------------
package nvp_pkg;

  localparam int CAPACITY = 16;
  localparam int HIT_AW   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  localparam int HIT_W = 40;     // part serial and vertex number

  localparam logic [23:0] Z_ONE     = 24'd65536;
  localparam logic [49:0] DIST_ONES = {1'b0, {49{1'b1}}};

  // configuration register indexes
  localparam logic [1:0] CFG_CURSOR_X = 2'd0;
  localparam logic [1:0] CFG_CURSOR_Y = 2'd1;
  localparam logic [1:0] CFG_WINDOW_X = 2'd2;
  localparam logic [1:0] CFG_WINDOW_Y = 2'd3;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_OFFER = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ACT_NONE     = 2'd0,
    ACT_NEW_BEST = 2'd1,
    ACT_TIE_ADD  = 2'd2,
    ACT_TIE_DROP = 2'd3
  } action_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [23:0] vert_x;
    logic [23:0] vert_y;
    logic [23:0] vert_z;
    logic [15:0] part_id;
    logic [23:0] vertex_id;
    logic [3:0]  read_index;
  } nvp_in_t;

  typedef struct packed {
    logic [4:0]  hit_total;
    logic        anything_found;
    logic        list_overflow;
    action_t     action;
    logic [15:0] read_part;
    logic [23:0] read_vertex;
    logic        read_valid;
  } nvp_out_t;

  // candidate handed from the geometry front end to the update stage
  typedef struct packed {
    cmd_t        cmd;
    logic [23:0] vert_x;
    logic [23:0] vert_y;
    logic [23:0] vert_z;
    logic [15:0] part_id;
    logic [23:0] vertex_id;
    logic [3:0]  read_index;
    logic        in_win;
    logic [48:0] sq_x;
    logic [48:0] sq_y;
  } nvp_cand_t;

endpackage

// ===== rtl/nearest_vertex_pick.sv =====
// ----------------------------------------------------------------------------
// nearest_vertex_pick
// keeps the projected vertex nearest to a cursor, with a list of tied hits
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while the output side is not
// stalled, and gives one registered result item for each. Two front stages
// form the cursor offsets with the window and depth test and then square
// them; the third stage adds the squares, compares with the stored best
// distance and updates the pick state in the same cycle, so that compare and
// update loop sets the rate. Hits (part serial and vertex number) sit in a 16
// entry ram, written on a new best or an appended tie and read through a
// registered port for the read command; only entries below hit_total are
// ever passed to the output, so the ram needs no clearing pass.
// The cursor and window registers may be written only while the block is idle.
// ----------------------------------------------------------------------------
module nearest_vertex_pick import nvp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  nvp_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output nvp_out_t    out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // configuration registers
  logic [15:0] cursor_x;
  logic [15:0] cursor_y;
  logic [11:0] window_x;
  logic [11:0] window_y;

  // candidate between the geometry front end and the update stage
  logic        cand_valid;
  logic        cand_ready;
  nvp_cand_t   cand;

  // register writes, window widths keep their low twelve bits
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x <= '0;
      cursor_y <= '0;
      window_x <= '0;
      window_y <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CURSOR_X: cursor_x <= cfg_data;
        CFG_CURSOR_Y: cursor_y <= cfg_data;
        CFG_WINDOW_X: window_x <= cfg_data[11:0];
        CFG_WINDOW_Y: window_y <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // offsets, window test and squares
  nvp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .cursor_x   (cursor_x),
    .cursor_y   (cursor_y),
    .window_x   (window_x),
    .window_y   (window_y),
    .cand_valid (cand_valid),
    .cand_ready (cand_ready),
    .cand       (cand)
  );

  // compare, state update, hit ram and output register
  nvp_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cand_valid (cand_valid),
    .cand_ready (cand_ready),
    .cand       (cand),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// ===== rtl/nvp_hit_ram.sv =====
// ----------------------------------------------------------------------------
// nvp_hit_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module nvp_hit_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/nvp_front.sv =====
// ----------------------------------------------------------------------------
// nvp_front
// offsets from the cursor, window and depth test, then squared offsets
// ----------------------------------------------------------------------------
module nvp_front import nvp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  nvp_in_t     in_data,
  input  logic [15:0] cursor_x,
  input  logic [15:0] cursor_y,
  input  logic [11:0] window_x,
  input  logic [11:0] window_y,
  output logic        cand_valid,
  input  logic        cand_ready,
  output nvp_cand_t   cand
);

  typedef struct packed {
    cmd_t        cmd;
    logic [23:0] vert_x;
    logic [23:0] vert_y;
    logic [23:0] vert_z;
    logic [15:0] part_id;
    logic [23:0] vertex_id;
    logic [3:0]  read_index;
    logic        in_win;
    logic [24:0] ax;
    logic [24:0] ay;
  } s1_t;

  s1_t         s1;
  logic        s1_valid;
  logic        s1_ready;
  logic        s2_ready;

  logic [24:0] dx, dy, ax, ay;
  logic        in_win;
  logic [49:0] px, py;

  // offsets in 1/256 pixel, magnitudes fit 25 bits unsigned
  always_comb begin
    dx = {cursor_x[15], cursor_x, 8'h00} - {in_data.vert_x[23], in_data.vert_x};
    dy = {cursor_y[15], cursor_y, 8'h00} - {in_data.vert_y[23], in_data.vert_y};
    ax = dx[24] ? (25'd0 - dx) : dx;
    ay = dy[24] ? (25'd0 - dy) : dy;
    in_win = !in_data.vert_z[23] && (in_data.vert_z <= Z_ONE) &&
             (ax <= {5'd0, window_x, 8'h00}) && (ay <= {5'd0, window_y, 8'h00});
  end

  assign s2_ready   = !cand_valid || cand_ready;
  assign s1_ready   = !s1_valid || s2_ready;
  assign in_ready   = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1.cmd        <= in_data.cmd;
      s1.vert_x     <= in_data.vert_x;
      s1.vert_y     <= in_data.vert_y;
      s1.vert_z     <= in_data.vert_z;
      s1.part_id    <= in_data.part_id;
      s1.vertex_id  <= in_data.vertex_id;
      s1.read_index <= in_data.read_index;
      s1.in_win     <= in_win;
      s1.ax         <= ax;
      s1.ay         <= ay;
    end
  end

  // squares, at most 2^48 each
  assign px = {25'd0, s1.ax} * {25'd0, s1.ax};
  assign py = {25'd0, s1.ay} * {25'd0, s1.ay};

  always_ff @(posedge clk) begin
    if (rst) begin
      cand_valid <= 1'b0;
    end else if (s2_ready) begin
      cand_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      cand.cmd        <= s1.cmd;
      cand.vert_x     <= s1.vert_x;
      cand.vert_y     <= s1.vert_y;
      cand.vert_z     <= s1.vert_z;
      cand.part_id    <= s1.part_id;
      cand.vertex_id  <= s1.vertex_id;
      cand.read_index <= s1.read_index;
      cand.in_win     <= s1.in_win;
      cand.sq_x       <= px[48:0];
      cand.sq_y       <= py[48:0];
    end
  end

endmodule

// ===== rtl/nvp_core.sv =====
// ----------------------------------------------------------------------------
// nvp_core
// best-distance compare, pick state update, hit list ram and result register
// ----------------------------------------------------------------------------
module nvp_core import nvp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cand_valid,
  output logic      cand_ready,
  input  nvp_cand_t cand,
  output logic      out_valid,
  input  logic      out_ready,
  output nvp_out_t  out_data
);

  logic             found, found_next;
  logic [23:0]      best_x, best_y, best_z;
  logic [23:0]      best_x_next, best_y_next, best_z_next;
  logic [49:0]      best_dist, best_dist_next;
  logic [CNT_W-1:0] hit_count, hit_count_next;
  logic             overflow, overflow_next;
  action_t          action_next;

  logic [49:0]      dist_sq;
  logic             is_new, is_tie, room, rd_hit, fire;

  logic              wr_en, rd_en;
  logic [HIT_AW-1:0] wr_addr;
  logic [HIT_W-1:0]  rd_data;

  logic [CNT_W-1:0] o_total;
  logic             o_found, o_ovf, o_rvalid;
  action_t          o_action;

  assign cand_ready = !out_valid || out_ready;
  assign fire       = cand_valid && cand_ready;

  always_comb begin
    dist_sq = {1'b0, cand.sq_x} + {1'b0, cand.sq_y};
    is_new  = (cand.cmd == CMD_OFFER) && cand.in_win && (dist_sq < best_dist);
    is_tie  = (cand.cmd == CMD_OFFER) && !is_new && found &&
              (best_x == cand.vert_x) && (best_y == cand.vert_y) &&
              (best_z == cand.vert_z);
    room    = hit_count < CAP_CNT;
    rd_hit  = (cand.cmd == CMD_READ) && ({1'b0, cand.read_index} < hit_count);

    found_next     = found;
    best_x_next    = best_x;
    best_y_next    = best_y;
    best_z_next    = best_z;
    best_dist_next = best_dist;
    hit_count_next = hit_count;
    overflow_next  = overflow;
    action_next    = ACT_NONE;
    wr_addr        = hit_count[HIT_AW-1:0];

    case (cand.cmd)
      CMD_CLEAR: begin
        found_next     = 1'b0;
        best_x_next    = '0;
        best_y_next    = '0;
        best_z_next    = '0;
        best_dist_next = DIST_ONES;
        hit_count_next = '0;
        overflow_next  = 1'b0;
      end
      CMD_OFFER: begin
        if (is_new) begin
          found_next     = 1'b1;
          best_x_next    = cand.vert_x;
          best_y_next    = cand.vert_y;
          best_z_next    = cand.vert_z;
          best_dist_next = dist_sq;
          hit_count_next = CNT_W'(1);
          action_next    = ACT_NEW_BEST;
          wr_addr        = '0;
        end else if (is_tie) begin
          if (room) begin
            hit_count_next = hit_count + CNT_W'(1);
            best_dist_next = dist_sq;
            action_next    = ACT_TIE_ADD;
          end else begin
            overflow_next  = 1'b1;
            action_next    = ACT_TIE_DROP;
          end
        end
      end
      default: ;
    endcase
  end

  assign wr_en = fire && (is_new || (is_tie && room));
  assign rd_en = fire && (cand.cmd == CMD_READ);

  nvp_hit_ram #(
    .WIDTH (HIT_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data ({cand.part_id, cand.vertex_id}),
    .rd_en   (rd_en),
    .rd_addr (cand.read_index[HIT_AW-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      found     <= 1'b0;
      best_x    <= '0;
      best_y    <= '0;
      best_z    <= '0;
      best_dist <= DIST_ONES;
      hit_count <= '0;
      overflow  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        found     <= found_next;
        best_x    <= best_x_next;
        best_y    <= best_y_next;
        best_z    <= best_z_next;
        best_dist <= best_dist_next;
        hit_count <= hit_count_next;
        overflow  <= overflow_next;
      end
      if (cand_ready) begin
        out_valid <= cand_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      o_total  <= hit_count_next;
      o_found  <= found_next;
      o_ovf    <= overflow_next;
      o_action <= action_next;
      o_rvalid <= rd_hit;
    end
  end

  always_comb begin
    out_data.hit_total      = o_total;
    out_data.anything_found = o_found;
    out_data.list_overflow  = o_ovf;
    out_data.action         = o_action;
    out_data.read_part      = o_rvalid ? rd_data[39:24] : 16'd0;
    out_data.read_vertex    = o_rvalid ? rd_data[23:0] : 24'd0;
    out_data.read_valid     = o_rvalid;
  end

endmodule

// ===== rtl/nvp_checker.sv =====
// ----------------------------------------------------------------------------
// nvp_checker
// port-level checks on the nearest vertex pick block, bound to the top level
// ----------------------------------------------------------------------------
module nvp_checker import nvp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  nvp_in_t     in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  nvp_out_t    out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  a_total_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.hit_total <= CAP_CNT)
    else $error("hit total beyond capacity");

  a_new_best: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.action == ACT_NEW_BEST) |->
      out_data.hit_total == CNT_W'(1) && out_data.anything_found)
    else $error("new best without a single hit");

  a_tie_drop: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.action == ACT_TIE_DROP) |->
      out_data.list_overflow && out_data.hit_total == CAP_CNT)
    else $error("tie dropped with room left or no overflow");

  a_read: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.read_valid |->
      out_data.action == ACT_NONE && out_data.hit_total != '0)
    else $error("read hit from an empty list or with an action");

endmodule

bind nearest_vertex_pick nvp_checker u_checker (.*);

// ===== sim/nearest_vertex_pick_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nearest_vertex_pick_tb
// self-checking bench: a class mirrors the pick state and predicts each result
// item, plain tasks drive vertex, clear and read items under random idling
// ----------------------------------------------------------------------------
module nearest_vertex_pick_tb;
  import nvp_pkg::*;

  localparam int   CYCLE_LIMIT  = 200000;
  localparam int   RANDOM_ITEMS = 1570;
  localparam int   NUM_PHASES   = 7;
  localparam int   MAX_REPORTS  = 60;
  localparam int   SETTLE_TIME  = 8;
  // spare command code, must leave the state alone
  localparam cmd_t CMD_UNUSED   = cmd_t'(2'b11);

  // one screen position with depth
  typedef struct packed {
    logic [23:0] x;
    logic [23:0] y;
    logic [23:0] z;
  } spot_t;

  // mirror of the pick state, predicts and checks result items
  class pick_mirror;
    logic signed [15:0] cursor_x, cursor_y;
    logic [11:0]        window_x, window_y;
    bit                 found;
    logic [23:0]        best_x, best_y, best_z;
    logic [48:0]        best_dist;
    logic [CNT_W-1:0]   hit_cnt;
    bit                 overflow;
    logic [15:0]        parts [CAPACITY];
    logic [23:0]        verts [CAPACITY];
    nvp_out_t           expected_picks [$];
    int unsigned        mismatches, checked;
    int unsigned        new_bests, ties_added, ties_dropped, hit_reads;

    function new();
      cursor_x = '0;
      cursor_y = '0;
      window_x = '0;
      window_y = '0;
      clear_pick();
    endfunction

    function void clear_pick();
      found     = 1'b0;
      best_x    = '0;
      best_y    = '0;
      best_z    = '0;
      best_dist = DIST_ONES[48:0];
      hit_cnt   = '0;
      overflow  = 1'b0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        CFG_CURSOR_X: cursor_x = val;
        CFG_CURSOR_Y: cursor_y = val;
        CFG_WINDOW_X: window_x = val[11:0];
        default:      window_y = val[11:0];
      endcase
    endfunction

    function int pending();
      return expected_picks.size();
    endfunction

    // work out the result of one accepted item and queue it
    function void note_item(nvp_in_t it);
      longint          dx, dy, vz;
      longint unsigned ax, ay, dist_sq;
      bit              in_range;
      nvp_out_t        res;
      res = '0;
      case (it.cmd)
        CMD_CLEAR: clear_pick();
        CMD_OFFER: begin
          dx = longint'(cursor_x) * 256 - longint'($signed(it.vert_x));
          dy = longint'(cursor_y) * 256 - longint'($signed(it.vert_y));
          vz = longint'($signed(it.vert_z));
          ax = (dx < 0) ? -dx : dx;
          ay = (dy < 0) ? -dy : dy;
          dist_sq = ax * ax + ay * ay;
          in_range = (vz >= 0) && (vz <= longint'(Z_ONE)) &&
                     (ax <= longint'(window_x) * 256) &&
                     (ay <= longint'(window_y) * 256);
          if (in_range && dist_sq < best_dist) begin
            hit_cnt    = 1;
            parts[0]   = it.part_id;
            verts[0]   = it.vertex_id;
            best_x     = it.vert_x;
            best_y     = it.vert_y;
            best_z     = it.vert_z;
            best_dist  = dist_sq[48:0];
            found      = 1'b1;
            res.action = ACT_NEW_BEST;
            new_bests++;
          end else if (found && best_x == it.vert_x && best_y == it.vert_y &&
                       best_z == it.vert_z) begin
            if (hit_cnt < CAP_CNT) begin
              parts[hit_cnt[HIT_AW-1:0]] = it.part_id;
              verts[hit_cnt[HIT_AW-1:0]] = it.vertex_id;
              hit_cnt++;
              best_dist  = dist_sq[48:0];
              res.action = ACT_TIE_ADD;
              ties_added++;
            end else begin
              overflow   = 1'b1;
              res.action = ACT_TIE_DROP;
              ties_dropped++;
            end
          end
        end
        CMD_READ: begin
          if (it.read_index < hit_cnt) begin
            res.read_part   = parts[it.read_index];
            res.read_vertex = verts[it.read_index];
            res.read_valid  = 1'b1;
            hit_reads++;
          end
        end
        default: ;
      endcase
      res.hit_total      = hit_cnt;
      res.anything_found = found;
      res.list_overflow  = overflow;
      expected_picks.push_back(res);
    endfunction

    function void check_field(string name, logic [23:0] want, logic [23:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: %s of result %0d: expected %0h, got %0h",
                   $time, name, checked, want, got);
      end
    endfunction

    function void check_result(nvp_out_t got);
      nvp_out_t want;
      if (expected_picks.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result item with no expectation waiting: expected none, got %h",
                   $time, got);
        return;
      end
      want = expected_picks.pop_front();
      checked++;
      check_field("hit_total", want.hit_total, got.hit_total);
      check_field("anything_found", want.anything_found, got.anything_found);
      check_field("list_overflow", want.list_overflow, got.list_overflow);
      check_field("action", want.action, got.action);
      check_field("read_part", want.read_part, got.read_part);
      check_field("read_vertex", want.read_vertex, got.read_vertex);
      check_field("read_valid", want.read_valid, got.read_valid);
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  nvp_in_t     in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  nvp_out_t    out_data;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = CFG_CURSOR_X;
  logic [15:0] cfg_data  = '0;

  // idling odds in percent per cycle, changed per phase
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int unsigned items_sent     = 0;
  int unsigned settings_used  = 0;
  int unsigned cycle_count    = 0;

  pick_mirror  mirror = new();

  nearest_vertex_pick dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver stalls at random, the odds set by the current phase
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // both handshakes sampled at the rising edge, before the block updates
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        mirror.note_item(in_data);
      if (out_valid && out_ready)
        mirror.check_result(out_data);
    end
  end

  // watchdog against a hung handshake
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, mirror.pending());
      $display("FAIL nearest_vertex_pick");
      $finish;
    end
  end

  // item with every field random and the given command
  function automatic nvp_in_t item_of(cmd_t c);
    nvp_in_t it;
    it.cmd        = c;
    it.vert_x     = 24'($urandom);
    it.vert_y     = 24'($urandom);
    it.vert_z     = 24'($urandom);
    it.part_id    = 16'($urandom);
    it.vertex_id  = 24'($urandom);
    it.read_index = 4'($urandom);
    return it;
  endfunction

  function automatic nvp_in_t offer_at(spot_t s);
    nvp_in_t it;
    it        = item_of(CMD_OFFER);
    it.vert_x = s.x;
    it.vert_y = s.y;
    it.vert_z = s.z;
    return it;
  endfunction

  function automatic nvp_in_t offer_xyz(longint x, longint y, longint z);
    return offer_at(spot_t'({24'(x), 24'(y), 24'(z)}));
  endfunction

  // reads mostly land inside the current list
  function automatic nvp_in_t read_item();
    nvp_in_t it;
    it = item_of(CMD_READ);
    if (mirror.hit_cnt != 0 && $urandom_range(9) < 7)
      it.read_index = 4'($urandom_range(mirror.hit_cnt - 1));
    return it;
  endfunction

  // coordinate near the cursor: window edges, just outside, or anywhere close
  function automatic logic [23:0] near_coord(logic signed [15:0] cur, logic [11:0] win);
    longint span, off;
    span = longint'(win) * 256;
    case ($urandom_range(9))
      0:       off = 0;
      1:       off = span;
      2:       off = -span;
      3:       off = span + 1;
      default: off = longint'($urandom_range(32'(2 * span + 512))) - span - 256;
    endcase
    return 24'(longint'(cur) * 256 + off);
  endfunction

  // depth mostly in range, with the bounds and a few rejects
  function automatic logic [23:0] pick_depth();
    case ($urandom_range(19))
      0:       return '0;
      1:       return Z_ONE;
      2:       return Z_ONE + 24'd1;
      3:       return '1;
      4:       return 24'($urandom);
      default: return 24'($urandom_range(32'(Z_ONE)));
    endcase
  endfunction

  function automatic spot_t near_spot();
    spot_t s;
    s.x = near_coord(mirror.cursor_x, mirror.window_x);
    s.y = near_coord(mirror.cursor_y, mirror.window_y);
    s.z = pick_depth();
    return s;
  endfunction

  // hold the item until accepted, with random gaps ahead of it
  task automatic send_item(nvp_in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    do begin
      @(posedge clk);
    end while (!in_ready);
    items_sent++;
  endtask

  // stop sending until every awaited result item is back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (mirror.pending() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    mirror.write_reg(idx, val);
  endtask

  // only called with the block idle
  task automatic apply_settings(logic [15:0] cx, logic [15:0] cy,
                                logic [15:0] wx, logic [15:0] wy);
    write_reg(CFG_CURSOR_X, cx);
    write_reg(CFG_CURSOR_Y, cy);
    write_reg(CFG_WINDOW_X, wx);
    write_reg(CFG_WINDOW_Y, wy);
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // mix of scenes around a few close positions, tie storms and plain noise
  task automatic run_phase(int unsigned quota);
    int unsigned start, kind, pick;
    bit          paused;
    spot_t       pool [4];
    spot_t       s;
    start  = items_sent;
    paused = 1'b0;
    while (items_sent - start < quota) begin
      // hold off once mid-phase until the pipeline is empty
      if (!paused && items_sent - start >= quota / 2) begin
        drain();
        paused = 1'b1;
      end
      kind = $urandom_range(99);
      if (kind < 60) begin
        // scene: repeated positions give new bests and ties in turn
        if ($urandom_range(9) < 7)
          send_item(item_of(CMD_CLEAR));
        foreach (pool[k])
          pool[k] = near_spot();
        repeat ($urandom_range(8, 40)) begin
          pick = $urandom_range(99);
          if (pick < 60)
            send_item(offer_at(pool[$urandom_range(3)]));
          else if (pick < 75)
            send_item(offer_at(near_spot()));
          else if (pick < 95)
            send_item(read_item());
          else
            send_item(item_of(cmd_t'($urandom_range(3))));
        end
      end else if (kind < 75) begin
        // tie storm: one position over and over, often past a full list
        s   = near_spot();
        s.z = 24'($urandom_range(32'(Z_ONE)));
        send_item(item_of(CMD_CLEAR));
        repeat ($urandom_range(14, 24))
          send_item(offer_at(s));
        repeat (2)
          send_item(read_item());
      end else begin
        repeat ($urandom_range(5, 15))
          send_item(item_of(cmd_t'($urandom_range(3))));
      end
    end
  endtask

  initial begin
    nvp_in_t it;
    longint  bx, by;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part, cursor at (10, -5) with a 4 pixel window
    apply_settings(16'd10, -16'sd5, 16'd4, 16'd4);
    bx = 10 * 256;
    by = -5 * 256;
    send_item(read_item());                              // read of an empty list
    send_item(offer_xyz(8388607, -8388608, -1));         // extremes, depth below zero
    send_item(offer_xyz(bx, by, 65537));                 // depth just over one
    send_item(offer_xyz(bx + 1025, by, 100));            // just outside the window
    it = offer_xyz(bx - 1024, by + 1024, 65536);         // first best on the corner
    it.part_id   = '1;
    it.vertex_id = '1;
    send_item(it);
    send_item(offer_xyz(bx + 1024, by - 1024, 65536));   // same distance, other place
    it = offer_xyz(bx - 1024, by + 1024, 65536);         // tie with the corner
    it.part_id   = '0;
    it.vertex_id = '0;
    send_item(it);
    // closer best, then ties until full and one dropped
    repeat (CAPACITY + 1)
      send_item(offer_xyz(bx + 3, by - 7, 0));
    it = item_of(CMD_READ);
    it.read_index = 4'(CAPACITY - 1);
    send_item(it);
    send_item(offer_xyz(bx, by, 32768));                 // new best, overflow kept
    send_item(item_of(CMD_UNUSED));
    drain();

    // cursor moved by a pixel, window shut: the stored best still ties
    apply_settings(16'd11, -16'sd5, 16'd0, 16'd0);
    send_item(offer_xyz(bx, by, 32768));
    send_item(offer_xyz(bx + 256, by, 1));
    send_item(item_of(CMD_CLEAR));
    drain();

    // random phases, each with its own settings and idling
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 45;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 45;
        end
        default: begin
          send_idle_pct  = 28;
          recv_stall_pct = 28;
        end
      endcase
      case (p)
        0: apply_settings(16'h8000, 16'h7fff, 16'd4095, 16'd4095);
        1: apply_settings(16'h7fff, 16'h8000, 16'd0, 16'd0);
        2: apply_settings(16'd123, -16'sd77, 16'd3, 16'd200);
        3: apply_settings(16'($urandom), 16'($urandom),
                          16'($urandom_range(1, 64)), 16'($urandom_range(1, 64)));
        4: apply_settings(-16'sd1, 16'd1, 16'd4095, 16'd0);
        5: apply_settings(16'($urandom), 16'($urandom),
                          16'($urandom_range(4095)), 16'($urandom_range(4095)));
        default: apply_settings(16'd0, 16'd0, 16'd1, 16'd1);
      endcase
      run_phase(RANDOM_ITEMS / NUM_PHASES);
      drain();
    end

    // let any stray result item show itself
    repeat (SETTLE_TIME) @(posedge clk);

    $display("%0d items sent under %0d register settings, %0d results checked",
             items_sent, settings_used, mirror.checked);
    $display("%0d new bests, %0d ties appended, %0d ties dropped, %0d hits read back",
             mirror.new_bests, mirror.ties_added, mirror.ties_dropped, mirror.hit_reads);
    if (mirror.mismatches == 0 && mirror.pending() == 0) begin
      $display("PASS nearest_vertex_pick");
    end else begin
      $display("FAIL nearest_vertex_pick");
    end
    $finish;
  end

endmodule
